// File: design/ring_neighbor_exclusion_arbiter_unit_assert.svh
// Assertion macros for the ring neighbor exclusion arbiter.
// Used by the port checker; needs i_clk and i_rst_n in scope.
`ifndef RING_NEIGHBOR_EXCLUSION_ARBITER_UNIT_ASSERT_SVH
`define RING_NEIGHBOR_EXCLUSION_ARBITER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RNEA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rnea assertion failed");

// Next-cycle implication, disabled during reset.
`define RNEA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rnea assertion failed");

`endif

// File: design/rnea_pkg.sv
// Shared types and codes of the ring neighbor exclusion arbiter.
// No dependencies.
package rnea_pkg;

    // Opcodes of an input item
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam int MASK_BITS = 8;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_GRANT = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] requester;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  granted_mask;
        logic [7:0]  holding_mask;
        logic [15:0] grant_count;
        logic [31:0] total_wait;
        logic        illegal;
    } t_out_item;

    // What a cell shows its two neighbors
    typedef struct packed {
        logic holding;    // currently granted
        logic releasing;  // this cell is the target of a legal release
        logic grant_l;    // granted as left neighbor of a release
    } t_nbr;

    // What a cell reports to the top level (values after the item)
    typedef struct packed {
        logic        granted;
        logic        holding;
        logic        legal;
        logic [15:0] grant_count;
        logic [31:0] total_wait;
    } t_cell_stat;

endpackage

// File: design/rnea_cell.sv
// One requester slot of the ring: phase, wait timer and saturating counters.
// Depends on rnea_pkg.
module rnea_cell import rnea_pkg::*; #(
    parameter int IDX       = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_in_item   i_item,
    input  t_nbr       i_left,
    input  t_nbr       i_right,
    output t_nbr       o_nbr,
    output t_cell_stat o_stat
);

    localparam bit ADDRESSABLE = (IDX < MASK_BITS);

    t_phase      r_phase, n_phase;
    logic [15:0] r_count, n_count;
    logic [31:0] r_sum, n_sum;
    logic [31:0] r_elapsed, n_elapsed;

    logic        is_req, req_ok, rel_ok;
    logic        left_eff, right_eff;
    logic        grant_q, grant_l, grant_r, grant;
    logic [31:0] wait_add;
    logic [32:0] sum_wide;

    // Neighbors count as holding unless they are being released now
    assign left_eff  = i_left.holding && !i_left.releasing;
    assign right_eff = i_right.holding && !i_right.releasing;

    assign is_req = ADDRESSABLE && (i_item.requester == 3'(IDX));
    assign req_ok = is_req && (i_item.opcode == OP_REQUEST) && (r_phase == PH_IDLE);
    assign rel_ok = is_req && (i_item.opcode == OP_RELEASE) && (r_phase == PH_GRANT);

    // Grant paths: own request, left of a release, right of a release
    assign grant_q = req_ok && !left_eff && !right_eff;
    assign grant_l = i_right.releasing && (r_phase == PH_WAIT) && !left_eff;
    assign grant_r = i_left.releasing && (r_phase == PH_WAIT) && !grant_l
                     && !left_eff && !right_eff && !i_left.grant_l && !i_right.grant_l;
    assign grant   = grant_q || grant_l || grant_r;

    // Wait of a fresh request is zero
    assign wait_add = req_ok ? 32'd0 : r_elapsed;
    assign sum_wide = {1'b0, r_sum} + {1'b0, wait_add};

    // Next state of the slot
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_sum     = r_sum;
        n_elapsed = r_elapsed;
        if (grant) begin
            n_phase = PH_GRANT;
            n_count = (r_count == 16'hFFFF) ? r_count : r_count + 16'd1;
            n_sum   = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
        end else if (req_ok) begin
            n_phase = PH_WAIT;
        end else if (rel_ok) begin
            n_phase = PH_IDLE;
        end
        if (req_ok) begin
            n_elapsed = 32'd0;
        end else if (i_item.opcode == OP_TICK) begin
            n_elapsed = r_elapsed + 32'd1;
        end
    end

    // Phase and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // Wait timer, meaningful only while waiting
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_elapsed <= n_elapsed;
        end
    end

    assign o_nbr.holding   = (r_phase == PH_GRANT);
    assign o_nbr.releasing = rel_ok;
    assign o_nbr.grant_l   = grant_l;

    assign o_stat.granted     = grant;
    assign o_stat.holding     = (n_phase == PH_GRANT);
    assign o_stat.legal       = req_ok || rel_ok;
    assign o_stat.grant_count = n_count;
    assign o_stat.total_wait  = n_sum;

endmodule

// File: design/ring_neighbor_exclusion_arbiter_unit.sv
// Ring neighbor exclusion arbiter.
// Input channel: i_in_valid / o_in_ready with i_in_item {opcode, requester}.
//   Opcode request marks an idle requester waiting and grants it if neither
//   ring neighbor holds a grant; release frees a granted requester and retests
//   its left, then right neighbor; tick advances time by one.
// Output channel: o_out_valid / i_out_ready with o_out_item, one result per
//   item: newly granted mask, holding mask, saturating grant count and wait
//   total of the addressed requester, and an illegal flag.
// Latency: the result is valid the cycle after the item is accepted.
// Throughput: one item per cycle while results are taken; every ring slot updates in the
//   same cycle and neighbors exchange holding and release status through the cell row.
// Reset (synchronous, active low): all requesters idle, counters zero, no
//   result pending.
// Stall: a result waits in the output register; a new item is taken in the
//   same cycle the pending result is taken, otherwise o_in_ready stays low.
// Depends on rnea_pkg and rnea_cell.
module ring_neighbor_exclusion_arbiter_unit import rnea_pkg::*; #(
    parameter int RING_SIZE = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int MASK_N = (RING_SIZE < MASK_BITS) ? RING_SIZE : MASK_BITS;

    logic       fire;
    logic       addr_ok;
    logic       any_legal;
    logic       r_out_valid;
    t_out_item  r_out_item, n_out_item;
    t_nbr       w_nbr  [RING_SIZE];
    t_cell_stat w_stat [RING_SIZE];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;

    // Row of ring cells, each wired to both neighbors
    for (genvar g = 0; g < RING_SIZE; g++) begin : g_cell
        rnea_cell #(
            .IDX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_fire  (fire),
            .i_item  (i_in_item),
            .i_left  (w_nbr[(g + RING_SIZE - 1) % RING_SIZE]),
            .i_right (w_nbr[(g + 1) % RING_SIZE]),
            .o_nbr   (w_nbr[g]),
            .o_stat  (w_stat[g])
        );
    end

    assign addr_ok = ({29'd0, i_in_item.requester} < 32'(RING_SIZE));

    // Result assembly from the cells' next values
    always_comb begin
        n_out_item = '0;
        any_legal  = 1'b0;
        for (int i = 0; i < RING_SIZE; i++) begin
            any_legal = any_legal | w_stat[i].legal;
        end
        for (int i = 0; i < MASK_N; i++) begin
            n_out_item.granted_mask[i] = w_stat[i].granted;
            n_out_item.holding_mask[i] = w_stat[i].holding;
            if (i_in_item.requester == 3'(i)) begin
                n_out_item.grant_count = w_stat[i].grant_count;
                n_out_item.total_wait  = w_stat[i].total_wait;
            end
        end
        if (!addr_ok) begin
            n_out_item.grant_count = '0;
            n_out_item.total_wait  = '0;
        end
        n_out_item.illegal = ((i_in_item.opcode == OP_REQUEST) ||
                              (i_in_item.opcode == OP_RELEASE)) && !any_legal;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: design/rnea_checker.sv
// Port-level checker for the ring neighbor exclusion arbiter, bound to the top.
// Depends on rnea_pkg and ring_neighbor_exclusion_arbiter_unit_assert.svh.
`include "ring_neighbor_exclusion_arbiter_unit_assert.svh"

module rnea_checker import rnea_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    logic [7:0] hold_m;
    logic [7:0] new_m;

    assign hold_m = o_out_item.holding_mask;
    assign new_m  = o_out_item.granted_mask;

    // A waiting input item holds
    `RNEA_ASSERT_NEXT(a_in_hold, i_in_valid && !o_in_ready, i_in_valid && $stable(i_in_item))

    // A stalled result holds
    `RNEA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))

    // A new grant is always a holder
    `RNEA_ASSERT_NOW(a_grant_holds, o_out_valid, (new_m & ~hold_m) == 8'd0)

    // No two adjacent mask bits hold at once; the ring pair of bits 7 and 0 is outside this check
    `RNEA_ASSERT_NOW(a_exclusion, o_out_valid, (hold_m & (hold_m >> 1)) == 8'd0)

    // An ignored item grants nothing
    `RNEA_ASSERT_NOW(a_illegal_quiet, o_out_valid && o_out_item.illegal, new_m == 8'd0)

endmodule

bind ring_neighbor_exclusion_arbiter_unit rnea_checker u_rnea_checker (.*);

// File: sim/testbench.sv
// Self-checking testbench for ring_neighbor_exclusion_arbiter_unit.
// Holds a grant ledger class that predicts every result and checks it in order.
// Depends on rnea_pkg and the arbiter RTL.
module testbench;
    import rnea_pkg::*;

    localparam int         RING_N     = 8;
    localparam int         NUM_RANDOM = 1800;
    localparam int         HOLD_OFF   = 400;
    localparam int         STALL_LIM  = 3000;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    // Predicts the arbiter's results and keeps the ones still due
    class grant_ledger;
        t_phase      phase [RING_N];
        logic [15:0] grant_total [RING_N];
        logic [31:0] wait_total [RING_N];
        logic [31:0] wait_stamp [RING_N];
        logic [31:0] now_tick;
        t_out_item   expected_results [$];
        int          errors;

        function new();
            for (int i = 0; i < RING_N; i++) begin
                phase[i]       = PH_IDLE;
                grant_total[i] = '0;
                wait_total[i]  = '0;
                wait_stamp[i]  = '0;
            end
            now_tick = '0;
            errors   = 0;
        endfunction

        // Grant a waiting requester whose neighbors hold nothing
        function logic [7:0] try_grant(int idx);
            int          lft;
            int          rgt;
            logic [31:0] waited;
            logic [32:0] sum;
            logic [7:0]  mask;
            lft  = (idx + RING_N - 1) % RING_N;
            rgt  = (idx + 1) % RING_N;
            mask = '0;
            if (phase[idx] != PH_WAIT || phase[lft] == PH_GRANT || phase[rgt] == PH_GRANT) begin
                return mask;
            end
            phase[idx] = PH_GRANT;
            waited = now_tick - wait_stamp[idx];
            sum = {1'b0, wait_total[idx]} + {1'b0, waited};
            wait_total[idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (grant_total[idx] != 16'hFFFF) begin
                grant_total[idx] = grant_total[idx] + 16'd1;
            end
            if (idx < MASK_BITS) begin
                mask[idx] = 1'b1;
            end
            return mask;
        endfunction

        // Apply one accepted item and queue the result it must give
        function void note_item(t_in_item it);
            int        r;
            t_out_item res;
            r   = int'(it.requester);
            res = '0;
            case (it.opcode)
                OP_REQUEST: begin
                    if (r >= RING_N || phase[r] != PH_IDLE) begin
                        res.illegal = 1'b1;
                    end else begin
                        phase[r]      = PH_WAIT;
                        wait_stamp[r] = now_tick;
                        res.granted_mask |= try_grant(r);
                    end
                end
                OP_RELEASE: begin
                    if (r >= RING_N || phase[r] != PH_GRANT) begin
                        res.illegal = 1'b1;
                    end else begin
                        phase[r] = PH_IDLE;
                        res.granted_mask |= try_grant((r + RING_N - 1) % RING_N);
                        res.granted_mask |= try_grant((r + 1) % RING_N);
                    end
                end
                OP_TICK: begin
                    now_tick = now_tick + 32'd1;
                end
                default: ;
            endcase
            for (int i = 0; i < RING_N && i < MASK_BITS; i++) begin
                if (phase[i] == PH_GRANT) begin
                    res.holding_mask[i] = 1'b1;
                end
            end
            if (r < RING_N) begin
                res.grant_count = grant_total[r];
                res.total_wait  = wait_total[r];
            end
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t MISMATCH %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one delivered result with the oldest one due
        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_results.size() == 0) begin
                $display("%0t MISMATCH unexpected result expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("granted_mask", 32'(want.granted_mask), 32'(got.granted_mask));
            compare_field("holding_mask", 32'(want.holding_mask), 32'(got.holding_mask));
            compare_field("grant_count", 32'(want.grant_count), 32'(got.grant_count));
            compare_field("total_wait", want.total_wait, got.total_wait);
            compare_field("illegal", 32'(want.illegal), 32'(got.illegal));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    grant_ledger ledger = new();
    int          quiet_cycles = 0;

    ring_neighbor_exclusion_arbiter_unit #(
        .RING_SIZE(RING_N)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Handshake monitor: predict on input, check on output
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                ledger.note_item(i_in_item);
            end
            if (o_out_valid && i_out_ready) begin
                ledger.check_result(o_out_item);
            end
        end
    end

    // Watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIM) begin
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offer one item and hold it until taken; called at a rising edge
    task automatic offer_item(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Mostly well-formed traffic steered by the predicted ring state
    function automatic t_in_item pick_item();
        t_in_item it;
        int       roll;
        int       cand [$];
        roll         = $urandom_range(0, 99);
        it.requester = 3'($urandom_range(0, 7));
        if (roll < 42) begin
            it.opcode = OP_REQUEST;
            for (int i = 0; i < RING_N; i++) begin
                if (ledger.phase[i] == PH_IDLE) cand.push_back(i);
            end
        end else if (roll < 77) begin
            it.opcode = OP_RELEASE;
            for (int i = 0; i < RING_N; i++) begin
                if (ledger.phase[i] == PH_GRANT) cand.push_back(i);
            end
        end else if (roll < 95) begin
            it.opcode = OP_TICK;
        end else begin
            it.opcode = OP_UNUSED;
        end
        if (cand.size() > 0 && $urandom_range(0, 99) < 85) begin
            it.requester = 3'(cand[$urandom_range(0, cand.size() - 1)]);
        end
        return it;
    endfunction

    // Receiver: random stall patterns plus one long hold-off
    initial begin
        int mode;
        int span;
        int stretch;
        stretch = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (stretch == 8) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            for (int c = 0; c < span; c++) begin
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    2:       i_out_ready <= ($urandom_range(0, 3) != 0);
                    default: i_out_ready <= ((c % 5) < 2);
                endcase
                @(posedge i_clk);
            end
            stretch++;
        end
    end

    // Stimulus and final verdict
    initial begin
        int sent;
        int burst;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: blocking by neighbors, retest order, illegal cases, unused opcode
        offer_item('{OP_REQUEST, 3'd0});
        offer_item('{OP_REQUEST, 3'd1});
        offer_item('{OP_REQUEST, 3'd7});
        offer_item('{OP_TICK,    3'd0});
        offer_item('{OP_TICK,    3'd5});
        offer_item('{OP_TICK,    3'd7});
        offer_item('{OP_REQUEST, 3'd0});
        offer_item('{OP_REQUEST, 3'd1});
        offer_item('{OP_RELEASE, 3'd1});
        offer_item('{OP_RELEASE, 3'd3});
        offer_item('{OP_REQUEST, 3'd4});
        offer_item('{OP_REQUEST, 3'd3});
        offer_item('{OP_RELEASE, 3'd0});
        offer_item('{OP_TICK,    3'd2});
        offer_item('{OP_RELEASE, 3'd4});
        offer_item('{OP_UNUSED,  3'd5});
        offer_item('{OP_UNUSED,  3'd2});
        offer_item('{OP_RELEASE, 3'd7});
        offer_item('{OP_RELEASE, 3'd1});
        offer_item('{OP_RELEASE, 3'd3});
        offer_item('{OP_REQUEST, 3'd6});
        offer_item('{OP_REQUEST, 3'd2});
        offer_item('{OP_REQUEST, 3'd5});
        offer_item('{OP_RELEASE, 3'd6});
        offer_item('{OP_RELEASE, 3'd2});

        // Random bursts with random gaps
        sent = 0;
        while (sent < NUM_RANDOM) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < NUM_RANDOM; k++) begin
                offer_item(pick_item());
                sent++;
            end
            pause_sender(($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12));
        end
        i_in_valid <= 1'b0;

        // Drain, then let the pipeline settle
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (ledger.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
